// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define NCO_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check on every clock edge, reset included.
`define NCO_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/nco_pkg.sv =====
// Constants, types and the arctangent table of the oscillator.
// No dependencies; used by the top level and its checker.
package nco_pkg;

    localparam int PHASE_BITS     = 32;
    localparam int OUT_BITS       = 16;
    localparam int STEP_BITS      = 32;
    localparam int TURN_BITS      = 32;
    localparam int COUNT_BITS     = 32;
    localparam int CORDIC_ITERS   = 30;
    localparam int ITER_W         = $clog2(CORDIC_ITERS);
    localparam int VEC_SCALE_BITS = 24;
    localparam int XY_W           = OUT_BITS + VEC_SCALE_BITS + 4;
    localparam int STEP_DN        = (PHASE_BITS < STEP_BITS) ? STEP_BITS - PHASE_BITS : 0;
    localparam int STEP_UP        = (PHASE_BITS > STEP_BITS) ? PHASE_BITS - STEP_BITS : 0;
    localparam int RND_SH         = TURN_BITS - 1 - OUT_BITS;

    localparam logic [STEP_BITS-1:0] STEP_RESET  = STEP_BITS'(4294967);
    localparam logic [TURN_BITS-1:0] CORDIC_GAIN = TURN_BITS'(652032874);

    typedef logic signed [OUT_BITS-1:0] sample_t;
    typedef logic [TURN_BITS-1:0]       turn_t;

    // arctangent of 2^-i in 2^32-per-turn units
    function automatic turn_t atan_turn(input logic [ITER_W-1:0] idx);
        turn_t a;
        unique case (idx)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            5'd24:   a = 32'd41;
            5'd25:   a = 32'd20;
            5'd26:   a = 32'd10;
            5'd27:   a = 32'd5;
            5'd28:   a = 32'd3;
            5'd29:   a = 32'd1;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== hdl/nco_sine_cosine_with_angle.sv =====
// Oscillator: phase accumulator, sine/cosine by rotating CORDIC, angle by vectoring CORDIC.
// Steps: accept, prepare, rotate, fold, set up vectoring, vector, load output once free.
// One item at a time: s_ready is high only in idle, so each item takes 30 rotation and
// 30 vectoring passes through the one shared add/shift unit, plus set-up and hand-off.
// Reset: synchronous, active low; clears accumulator, tick count and output valid, step back to 4294967.
// Depends on nco_pkg.
module nco_sine_cosine_with_angle (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic signed [nco_pkg::STEP_BITS-1:0] cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_tick,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [nco_pkg::COUNT_BITS-1:0]    m_sample_count,
    output logic [nco_pkg::OUT_BITS-1:0]      m_phase,
    output nco_pkg::sample_t                  m_sine,
    output nco_pkg::sample_t                  m_cosine,
    output nco_pkg::sample_t                  m_angle
);
    import nco_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_ROT   = 3'd2;
    localparam logic [2:0] S_FOLD  = 3'd3;
    localparam logic [2:0] S_VINIT = 3'd4;
    localparam logic [2:0] S_VEC   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam logic signed [XY_W-1:0] RND_ONE   = XY_W'(2 ** (RND_SH - 1));
    localparam logic signed [XY_W-1:0] CLAMP_POS = XY_W'(2 ** (OUT_BITS - 1) - 1);
    localparam logic signed [XY_W-1:0] CLAMP_NEG = -CLAMP_POS;
    localparam turn_t QUAD_HALF = TURN_BITS'(2 ** (TURN_BITS - 3));
    localparam turn_t HALF_TURN = TURN_BITS'(2 ** (TURN_BITS - 1));
    localparam turn_t ANG_HALF  = TURN_BITS'(2 ** RND_SH);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERS - 1);

    function automatic sample_t round_clamp(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0] r;
        r = (v + RND_ONE) >>> RND_SH;
        if (r > CLAMP_POS) begin
            r = CLAMP_POS;
        end else if (r < CLAMP_NEG) begin
            r = CLAMP_NEG;
        end
        return sample_t'(r);
    endfunction

    logic [2:0]                  state_reg, state_next;
    logic signed [STEP_BITS-1:0] phase_step_reg, phase_step_next;
    logic [PHASE_BITS-1:0]       acc_reg, acc_next;
    logic [COUNT_BITS-1:0]       count_reg, count_next;
    logic                        m_valid_reg, m_valid_next;

    logic signed [XY_W-1:0]      x_reg, x_next, y_reg, y_next;
    turn_t                       z_reg, z_next;
    logic [ITER_W-1:0]           iter_reg, iter_next;
    logic [1:0]                  quad_reg, quad_next;
    sample_t                     sin_reg, sin_next, cos_reg, cos_next;
    logic                        zero_reg, zero_next;
    logic [COUNT_BITS-1:0]       out_count_reg, out_count_next;
    logic [OUT_BITS-1:0]         out_phase_reg, out_phase_next;
    sample_t                     out_sin_reg, out_sin_next;
    sample_t                     out_cos_reg, out_cos_next;
    sample_t                     out_ang_reg, out_ang_next;

    logic signed [63:0]                  step_ext;
    logic [PHASE_BITS-1:0]               acc_step;
    logic [PHASE_BITS+TURN_BITS-1:0]     acc_ext;
    turn_t                               theta, theta_plus, residue, atan_val, ang_sum;
    logic [1:0]                          quad;
    logic signed [XY_W-1:0]              dx, dy, cos_sc, sin_sc;
    logic                                ccw, last_iter, out_load;
    sample_t                             c_rnd, s_rnd;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_sample_count = out_count_reg;
    assign m_phase   = out_phase_reg;
    assign m_sine    = out_sin_reg;
    assign m_cosine  = out_cos_reg;
    assign m_angle   = out_ang_reg;

    assign step_ext   = 64'(phase_step_reg);
    assign acc_step   = PHASE_BITS'(64'((step_ext >>> STEP_DN) <<< STEP_UP));
    assign acc_ext    = {acc_reg, {TURN_BITS{1'b0}}};
    assign theta      = TURN_BITS'(acc_ext >> PHASE_BITS);
    assign theta_plus = theta + QUAD_HALF;
    assign quad       = theta_plus[TURN_BITS-1 -: 2];
    assign residue    = theta - {quad, {(TURN_BITS-2){1'b0}}};

    assign dx        = y_reg >>> iter_reg;
    assign dy        = x_reg >>> iter_reg;
    assign atan_val  = atan_turn(iter_reg);
    assign ccw       = (state_reg == S_VEC) ? y_reg[XY_W-1] : !z_reg[TURN_BITS-1];
    assign last_iter = (iter_reg == ITER_LAST);

    assign c_rnd   = round_clamp(x_reg);
    assign s_rnd   = round_clamp(y_reg);
    assign cos_sc  = XY_W'(cos_reg) <<< VEC_SCALE_BITS;
    assign sin_sc  = XY_W'(sin_reg) <<< VEC_SCALE_BITS;
    assign ang_sum = z_reg + ANG_HALF;

    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next      = state_reg;
        phase_step_next = phase_step_reg;
        acc_next        = acc_reg;
        count_next      = count_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        iter_next       = iter_reg;
        quad_next       = quad_reg;
        sin_next        = sin_reg;
        cos_next        = cos_reg;
        zero_next       = zero_reg;
        out_count_next  = out_count_reg;
        out_phase_next  = out_phase_reg;
        out_sin_next    = out_sin_reg;
        out_cos_next    = out_cos_reg;
        out_ang_next    = out_ang_reg;
        m_valid_next    = m_valid_reg && !m_ready;

        if (cfg_valid && cfg_ready) begin
            phase_step_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_tick) begin
                        acc_next   = acc_reg + acc_step;
                        count_next = count_reg + 1'b1;
                    end
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                x_next     = XY_W'(CORDIC_GAIN);
                y_next     = '0;
                z_next     = residue;
                quad_next  = quad;
                iter_next  = '0;
                state_next = S_ROT;
            end
            S_ROT, S_VEC: begin
                if (ccw) begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_val;
                end else begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_val;
                end
                iter_next = iter_reg + 1'b1;
                if (last_iter) begin
                    state_next = (state_reg == S_ROT) ? S_FOLD : S_DONE;
                end
            end
            S_FOLD: begin
                unique case (quad_reg)
                    2'd0: begin
                        cos_next = c_rnd;
                        sin_next = s_rnd;
                    end
                    2'd1: begin
                        cos_next = -s_rnd;
                        sin_next = c_rnd;
                    end
                    2'd2: begin
                        cos_next = -c_rnd;
                        sin_next = -s_rnd;
                    end
                    default: begin
                        cos_next = s_rnd;
                        sin_next = -c_rnd;
                    end
                endcase
                state_next = S_VINIT;
            end
            S_VINIT: begin
                if (cos_reg[OUT_BITS-1]) begin
                    x_next = -cos_sc;
                    y_next = -sin_sc;
                    z_next = HALF_TURN;
                end else begin
                    x_next = cos_sc;
                    y_next = sin_sc;
                    z_next = '0;
                end
                zero_next  = (sin_reg == '0) && (cos_reg == '0);
                iter_next  = '0;
                state_next = S_VEC;
            end
            S_DONE: begin
                if (out_load) begin
                    out_count_next = count_reg;
                    out_phase_next = theta[TURN_BITS-1 -: OUT_BITS];
                    out_sin_next   = sin_reg;
                    out_cos_next   = cos_reg;
                    out_ang_next   = zero_reg ? sample_t'(0)
                                              : sample_t'(ang_sum[TURN_BITS-1 -: OUT_BITS]);
                    m_valid_next   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            phase_step_reg <= STEP_RESET;
            acc_reg        <= '0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_step_reg <= phase_step_next;
            acc_reg        <= acc_next;
            count_reg      <= count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        z_reg         <= z_next;
        iter_reg      <= iter_next;
        quad_reg      <= quad_next;
        sin_reg       <= sin_next;
        cos_reg       <= cos_next;
        zero_reg      <= zero_next;
        out_count_reg <= out_count_next;
        out_phase_reg <= out_phase_next;
        out_sin_reg   <= out_sin_next;
        out_cos_reg   <= out_cos_next;
        out_ang_reg   <= out_ang_next;
    end

endmodule

// ===== hdl/nco_chk.sv =====
// Port-level checker for the oscillator, bound to the top level below.
// Depends on nco_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nco_chk (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [nco_pkg::COUNT_BITS-1:0]    m_sample_count,
    input logic [nco_pkg::OUT_BITS-1:0]      m_phase,
    input nco_pkg::sample_t                  m_sine,
    input nco_pkg::sample_t                  m_cosine,
    input nco_pkg::sample_t                  m_angle
);
    import nco_pkg::*;

    // busy after taking an item
    `NCO_ASSERT(a_busy_after_accept, s_valid && s_ready |=> !s_ready, "ready held after accept")

    // a new result only ever follows a busy cycle
    `NCO_ASSERT(a_result_after_work, $rose(m_valid) |-> !$past(s_ready), "result without work")

    // hold a stalled item
    `NCO_ASSERT(a_out_hold, m_valid && !m_ready |=> m_valid && $stable(m_sample_count) && $stable(m_phase) && $stable(m_sine) && $stable(m_cosine) && $stable(m_angle), "stalled item changed")

    // drop any result on reset
    `NCO_ASSERT_RST(a_reset_clears, !aresetn |=> !m_valid, "valid after reset")

endmodule

bind nco_sine_cosine_with_angle nco_chk u_nco_chk (.*);
